// ===== rtl/core/typed_message_queue_assert.svh =====
// Assertion macros shared by the typed message queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TYPED_MESSAGE_QUEUE_ASSERT_SVH
`define TYPED_MESSAGE_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/tmq_pkg.sv =====
// Package for the typed message queue: sizes, codes, state type and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package tmq_pkg;
   localparam int MAX_MSGS      = 64;
   localparam int IDX_W         = $clog2(MAX_MSGS);
   localparam int CNT_W         = IDX_W + 1;
   localparam int MAX_MSG_BYTES = 4096;
   localparam logic [15:0] LIMIT_RESET = 16'd16384;

   localparam logic [1:0] REQ_SEND  = 2'd0;
   localparam logic [1:0] REQ_RECV  = 2'd1;
   localparam logic [1:0] REQ_FLUSH = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_NOMATCH = 3'd3;
   localparam logic [2:0] ST_SMALL   = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic shift;
      logic shift_end;
      logic finish;
   } tmq_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic shift_needed;
      logic shift_done;
      logic out_free;
   } tmq_stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/typed_message_queue.sv =====
// Top level of the typed message queue: APB-style register port plus the
// controller and datapath. Depends on tmq_pkg, tmq_ctrl and tmq_dp.
//
// Requests arrive on the req_ channel (valid/stall) and every request gives
// exactly one result transfer on the rsp_ channel. A send appends a message,
// a receive removes one chosen by the selector, a flush empties the queue.
// One request is worked on at a time. A send, a flush or a bad request
// passes through the scan, decide and finish steps. A receive scans every
// held message, then decides, then compacts the entries behind the removed
// message when one is removed, and then finishes. The scan and the
// compaction both read the message stores through their registered read.
// The result register frees the request side: a new request may be taken
// while a result still waits, and the block holds in its final step only
// when the result register is still occupied and stalled.
// Reset empties the queue and sets the byte limit to 16384; the stores need
// no clearing. The byte limit is register 0 at address 0; the user must see that it is
// written only while the block is idle, as the block itself does not enforce it.
`default_nettype none
module typed_message_queue import tmq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic signed [31:0] req_msg_type,
   input  wire logic [15:0] req_msg_length,
   input  wire logic [63:0] req_msg_payload,
   input  wire logic        req_allow_truncate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [30:0]      rsp_out_type,
   output logic [12:0]      rsp_out_length,
   output logic [63:0]      rsp_out_payload,
   output logic [6:0]       rsp_msg_count,
   output logic [15:0]      rsp_bytes_held,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   tmq_cmd_type  cmd;
   tmq_stat_type stat;
   logic         limit_we;
   logic [15:0]  limit;

   assign pready   = 1'b1;
   assign limit_we = psel && penable && pwrite && !paddr[2];
   assign prdata   = paddr[2] ? 32'd0 : {16'd0, limit};

   tmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tmq_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_type           (req_type),
      .req_msg_type       (req_msg_type),
      .req_msg_length     (req_msg_length),
      .req_msg_payload    (req_msg_payload),
      .req_allow_truncate (req_allow_truncate),
      .limit_we           (limit_we),
      .limit_wdata        (pwdata[15:0]),
      .limit              (limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_type       (rsp_out_type),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_msg_count      (rsp_msg_count),
      .rsp_bytes_held     (rsp_bytes_held)
   );
endmodule
`default_nettype wire

// ===== rtl/core/tmq_ctrl.sv =====
// Controller state machine of the typed message queue.
// Depends on tmq_pkg; drives the datapath through tmq_cmd_type commands.
`default_nettype none
module tmq_ctrl import tmq_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  tmq_stat_type stat,
   output tmq_cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN:   if (stat.scan_done) state_in = S_DECIDE;
         S_DECIDE: state_in = stat.shift_needed ? S_SHIFT : S_FINISH;
         S_SHIFT:  if (stat.shift_done) state_in = S_FINISH;
         S_FINISH: if (stat.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_SCAN:   cmd.scan = 1'b1;
         S_DECIDE: cmd.decide = 1'b1;
         S_SHIFT: begin
            cmd.shift     = 1'b1;
            cmd.shift_end = stat.shift_done;
         end
         S_FINISH: cmd.finish = stat.out_free;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/tmq_dp.sv =====
// Datapath of the typed message queue: message stores, scan, compaction,
// counters, limit register and result register.
// Depends on tmq_pkg and typed_message_queue_assert.svh.
`default_nettype none
`include "typed_message_queue_assert.svh"
module tmq_dp import tmq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  tmq_cmd_type      cmd,
   output tmq_stat_type     stat,
   input  wire logic [1:0]  req_type,
   input  wire logic signed [31:0] req_msg_type,
   input  wire logic [15:0] req_msg_length,
   input  wire logic [63:0] req_msg_payload,
   input  wire logic        req_allow_truncate,
   input  wire logic        limit_we,
   input  wire logic [15:0] limit_wdata,
   output logic [15:0]      limit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [30:0]      rsp_out_type,
   output logic [12:0]      rsp_out_length,
   output logic [63:0]      rsp_out_payload,
   output logic [6:0]       rsp_msg_count,
   output logic [15:0]      rsp_bytes_held
);
   logic [30:0] type_mem [MAX_MSGS];
   logic [12:0] len_mem  [MAX_MSGS];
   logic [63:0] pay_mem  [MAX_MSGS];

   logic [1:0]  req_ff;
   logic [31:0] sel_ff;
   logic [15:0] cap_ff;
   logic [63:0] pay_ff;
   logic        trunc_ff;

   logic [CNT_W-1:0] count_ff;
   logic [15:0]      bytes_ff, limit_ff;
   logic [CNT_W-1:0] ptr_ff;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [30:0]      rd_type_ff;
   logic [12:0]      rd_len_ff;
   logic [63:0]      rd_pay_ff;

   logic             found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [30:0]      best_type_ff;
   logic [12:0]      best_len_ff;
   logic [63:0]      best_pay_ff;

   logic [2:0]  status_ff;
   logic [30:0] otype_ff;
   logic [12:0] olen_ff;
   logic [63:0] opay_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [30:0]      rsp_type_ff;
   logic [12:0]      rsp_len_ff;
   logic [63:0]      rsp_pay_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [15:0]      rsp_bytes_ff;

   logic             issue, hit, we, is_recv, too_small;
   logic [IDX_W-1:0] waddr;
   logic [31:0]      mag;
   logic [16:0]      bytes_sum;

   assign is_recv   = (req_ff == REQ_RECV);
   assign issue     = (cmd.scan || cmd.shift) && is_recv && (ptr_ff < count_ff);
   assign rd_valid_in = issue;
   assign mag       = (~sel_ff) + 32'd1;
   assign bytes_sum = {1'b0, bytes_ff} + {1'b0, cap_ff};
   assign too_small = ({3'd0, best_len_ff} > cap_ff) && !trunc_ff;

   always_comb begin
      hit = 1'b0;
      if (rd_valid_ff) begin
         priority if (sel_ff == 32'd0) begin
            hit = !found_ff;
         end else if (!sel_ff[31]) begin
            hit = !found_ff && ({1'b0, rd_type_ff} == sel_ff);
         end else begin
            hit = ({1'b0, rd_type_ff} <= mag) && (!found_ff || rd_type_ff < best_type_ff);
         end
      end
   end

   assign stat.scan_done    = !is_recv || (ptr_ff >= count_ff && !rd_valid_ff);
   assign stat.shift_needed = is_recv && found_ff && !too_small;
   assign stat.shift_done   = (ptr_ff >= count_ff) && !rd_valid_ff;
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      we    = 1'b0;
      waddr = count_ff[IDX_W-1:0];
      if (cmd.decide && req_ff == REQ_SEND && !sel_ff[31] && sel_ff != 32'd0 &&
          cap_ff <= 16'(MAX_MSG_BYTES) && count_ff < CNT_W'(MAX_MSGS) &&
          bytes_sum <= {1'b0, limit_ff}) begin
         we = 1'b1;
      end else if (cmd.shift && rd_valid_ff) begin
         we    = 1'b1;
         waddr = rd_idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         type_mem[waddr] <= cmd.decide ? sel_ff[30:0] : rd_type_ff;
         len_mem[waddr]  <= cmd.decide ? cap_ff[12:0] : rd_len_ff;
         pay_mem[waddr]  <= cmd.decide ? pay_ff : rd_pay_ff;
      end
      rd_type_ff <= type_mem[ptr_ff[IDX_W-1:0]];
      rd_len_ff  <= len_mem[ptr_ff[IDX_W-1:0]];
      rd_pay_ff  <= pay_mem[ptr_ff[IDX_W-1:0]];
      rd_idx_ff  <= ptr_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_type;
         sel_ff   <= req_msg_type;
         cap_ff   <= req_msg_length;
         pay_ff   <= req_msg_payload;
         trunc_ff <= req_allow_truncate;
      end
      if (hit) begin
         best_idx_ff  <= rd_idx_ff;
         best_type_ff <= rd_type_ff;
         best_len_ff  <= rd_len_ff;
         best_pay_ff  <= rd_pay_ff;
      end
      if (cmd.decide) begin
         otype_ff <= '0;
         olen_ff  <= '0;
         opay_ff  <= '0;
         unique case (req_ff)
            REQ_SEND: begin
               if (sel_ff[31] || sel_ff == 32'd0 || cap_ff > 16'(MAX_MSG_BYTES)) begin
                  status_ff <= ST_BAD;
               end else if (!we) begin
                  status_ff <= ST_FULL;
               end else begin
                  status_ff <= ST_OK;
               end
            end
            REQ_RECV: begin
               if (!found_ff) begin
                  status_ff <= ST_NOMATCH;
               end else if (too_small) begin
                  status_ff <= ST_SMALL;
               end else begin
                  status_ff <= ST_OK;
                  otype_ff  <= best_type_ff;
                  olen_ff   <= ({3'd0, best_len_ff} > cap_ff) ? cap_ff[12:0] : best_len_ff;
                  opay_ff   <= best_pay_ff;
               end
            end
            REQ_FLUSH: status_ff <= ST_OK;
            default:   status_ff <= ST_BAD;
         endcase
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_type_ff   <= otype_ff;
         rsp_len_ff    <= olen_ff;
         rsp_pay_ff    <= opay_ff;
         rsp_count_ff  <= count_ff;
         rsp_bytes_ff  <= bytes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bytes_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         if (limit_we) begin
            limit_ff <= limit_wdata;
         end
         if (cmd.load) begin
            ptr_ff   <= '0;
            found_ff <= 1'b0;
         end else if (issue) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end else if (cmd.decide) begin
            ptr_ff <= {1'b0, best_idx_ff} + CNT_W'(1);
         end
         if (hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.decide) begin
            if (req_ff == REQ_SEND && we) begin
               count_ff <= count_ff + CNT_W'(1);
               bytes_ff <= bytes_sum[15:0];
            end else if (req_ff == REQ_FLUSH) begin
               count_ff <= '0;
               bytes_ff <= '0;
            end else if (stat.shift_needed) begin
               bytes_ff <= bytes_ff - {3'd0, best_len_ff};
            end
         end
         if (cmd.shift_end) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign limit           = limit_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_type    = rsp_type_ff;
   assign rsp_out_length  = rsp_len_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_msg_count   = rsp_count_ff;
   assign rsp_bytes_held  = rsp_bytes_ff;

   `TMQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_MSGS))
   `TMQ_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff)
   `TMQ_ASSERT_NOW(a_fail_no_data, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_len_ff == 13'd0 && rsp_type_ff == 31'd0)
endmodule
`default_nettype wire
